### design/bemf_zero_cross_detector_unit_defines.svh
// Assertion macros for the back-EMF zero-crossing detector.
`ifndef BEMF_ZERO_CROSS_DETECTOR_UNIT_DEFINES_SVH
`define BEMF_ZERO_CROSS_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BZCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BZCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bzcd_pkg.sv
`default_nettype none

package bzcd_pkg;

    localparam int unsigned OFFSET_WIDTH = 10;
    localparam int unsigned BUS_LSB_DROP = 4;

    // x / 5 == (x * 52429) >> 18, exact for x below 2**16
    localparam logic [16:0] DIV5_MUL   = 17'd52429;
    localparam int unsigned DIV5_SHIFT = 18;

    typedef enum logic {
        CFG_REVERSE_DIRECTION = 1'b0,
        CFG_CENTER_OFFSET     = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic window_ok;
        logic qualify;
    } t_eval;

endpackage

`default_nettype wire

### design/bemf_zero_cross_detector_unit.sv
// Back-EMF zero-crossing detector for a sensorless six-step drive. Each item
// carries the commutation step, the bus voltage and the three back-EMF samples;
// each item yields exactly one result, zero_cross, which is 1 on the second of
// two consecutive in-window qualifying samples. One item is accepted every
// cycle unless o_in_stall holds the input; each item passes from the input
// register to the result register, and a new item can enter the input register
// while a stalled result waits. Config writes (index 0 direction, index 1 offset)
// are always ready and take effect on the next item evaluated.

`default_nettype none

`include "bemf_zero_cross_detector_unit_defines.svh"

module bemf_zero_cross_detector_unit
    import bzcd_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [OFFSET_WIDTH-1:0]   i_cfg_data,

    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [2:0]                i_phase,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_bus_voltage,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_bemf_a,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_bemf_b,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_bemf_c,

    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_zero_cross
);

    logic                     r_reverse_direction;
    logic [OFFSET_WIDTH-1:0]  r_center_offset;

    logic                     r_in_valid;
    logic [2:0]               r_phase;
    logic [SAMPLE_WIDTH-1:0]  r_bus_voltage;
    logic [SAMPLE_WIDTH-1:0]  r_bemf_a;
    logic [SAMPLE_WIDTH-1:0]  r_bemf_b;
    logic [SAMPLE_WIDTH-1:0]  r_bemf_c;

    logic                     r_count;
    logic                     r_out_valid;
    logic                     r_zero_cross;

    logic                     n_count;
    logic                     n_zero_cross;
    logic                     in_load;
    logic                     advance;
    t_eval                    ev;

    assign o_cfg_ready  = 1'b1;
    assign advance      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall   = r_in_valid && !advance;
    assign in_load      = i_in_valid && !o_in_stall;
    assign o_out_valid  = r_out_valid;
    assign o_zero_cross = r_zero_cross;

    bzcd_eval #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_eval (
        .i_phase             (r_phase),
        .i_bus_voltage       (r_bus_voltage),
        .i_bemf_a            (r_bemf_a),
        .i_bemf_b            (r_bemf_b),
        .i_bemf_c            (r_bemf_c),
        .i_reverse_direction (r_reverse_direction),
        .i_center_offset     (r_center_offset),
        .o_eval              (ev)
    );

    always_comb begin
        n_count      = 1'b0;
        n_zero_cross = 1'b0;
        if (ev.window_ok && ev.qualify) begin
            n_count      = !r_count;
            n_zero_cross = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse_direction <= 1'b0;
            r_center_offset     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REVERSE_DIRECTION: r_reverse_direction <= i_cfg_data[0];
                CFG_CENTER_OFFSET:     r_center_offset     <= i_cfg_data;
                default:               r_center_offset     <= r_center_offset;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_phase       <= i_phase;
            r_bus_voltage <= i_bus_voltage;
            r_bemf_a      <= i_bemf_a;
            r_bemf_b      <= i_bemf_b;
            r_bemf_c      <= i_bemf_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_zero_cross <= n_zero_cross;
        end
    end

    `BZCD_ASSERT_NEXT(a_detect_on_second, i_clk, i_rst_n,
        advance && r_count && ev.window_ok && ev.qualify,
        o_out_valid && o_zero_cross && !r_count,
        "second qualifying item must detect and clear count")
    `BZCD_ASSERT_NEXT(a_miss_clears, i_clk, i_rst_n,
        advance && !(ev.window_ok && ev.qualify),
        !r_count && !o_zero_cross,
        "non-qualifying item must clear count without detect")
    `BZCD_ASSERT_NOW(a_detect_count_clear, i_clk, i_rst_n,
        o_out_valid && o_zero_cross, !r_count,
        "count must be clear while a detect is shown")

endmodule

`default_nettype wire

### design/bzcd_eval.sv
`default_nettype none

module bzcd_eval
    import bzcd_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 12
) (
    input  wire logic [2:0]                i_phase,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_bus_voltage,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_bemf_a,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_bemf_b,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_bemf_c,
    input  wire logic                      i_reverse_direction,
    input  wire logic [OFFSET_WIDTH-1:0]   i_center_offset,
    output t_eval                          o_eval
);

    localparam int unsigned W     = SAMPLE_WIDTH;
    localparam int unsigned PW    = W + 17;
    localparam int unsigned CW    = ((W > OFFSET_WIDTH) ? W : OFFSET_WIDTH) + 1;

    logic [W-1:0]  vs;
    logic [PW-1:0] prod;
    logic [W-1:0]  lower;
    logic [W-1:0]  higher;
    logic [W-1:0]  centre;
    logic [W-1:0]  sample;
    logic          phase_ok;
    logic [CW-1:0] centre_x;
    logic [CW-1:0] offset_x;
    logic [CW-1:0] sample_x;
    logic [CW-1:0] thr_low;
    logic [CW-1:0] thr_high;

    assign vs     = {i_bus_voltage[W-1:BUS_LSB_DROP], {BUS_LSB_DROP{1'b0}}};
    assign prod   = PW'(vs) * PW'(DIV5_MUL);
    assign lower  = {1'b0, prod[PW-1:DIV5_SHIFT]};
    assign higher = vs - lower;
    assign centre = {1'b0, vs[W-1:1]};

    always_comb begin
        phase_ok = 1'b1;
        case (i_phase)
            3'd0, 3'd3: begin
                sample = i_reverse_direction ? i_bemf_a : i_bemf_c;
            end
            3'd1, 3'd4: begin
                sample = i_bemf_b;
            end
            3'd2, 3'd5: begin
                sample = i_reverse_direction ? i_bemf_c : i_bemf_a;
            end
            default: begin
                sample   = '0;
                phase_ok = 1'b0;
            end
        endcase
    end

    assign centre_x = CW'(centre);
    assign offset_x = CW'(i_center_offset);
    assign sample_x = CW'(sample);
    assign thr_low  = (centre_x > offset_x) ? (centre_x - offset_x) : '0;
    assign thr_high = centre_x + offset_x;

    assign o_eval.window_ok = phase_ok && (sample < higher) && (sample > lower);
    assign o_eval.qualify   = i_phase[0] ? (sample_x > thr_low) : (sample_x < thr_high);

endmodule

`default_nettype wire
